// ===== rtl/mfss_pkg.sv =====
// Package for the maximal free square scan block.
// Holds field widths, register indexes, reset values and the free-cell code.
// No dependencies.
package mfss_pkg;

	localparam int SCORE_W   = 11;
	localparam int ROW_W     = 16;
	localparam int GW_W      = 11;
	localparam int COL_OUT_W = 10;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [7:0]         FREE_CHAR = 8'h2E;
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
	localparam logic [ROW_W-1:0] GRID_HEIGHT_RST = 16'd1024;

	typedef enum logic [0:0] {
		REG_GRID_WIDTH  = 1'b0,
		REG_GRID_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

// ===== rtl/maximal_free_square_scan.sv =====
// Maximal free square scan: top level.
// Depends on mfss_pkg and mfss_ram.
//
// Usage:
//   Cells enter on the in_valid/in_ready channel in raster order, one
//   character per request; '.' is free, anything else is an obstacle.
//   After the last cell of a grid (grid_width x grid_height, set over the
//   APB port) one result leaves on out_valid/out_ready: the side of the
//   largest free square and the row and column of the bottom-right cell
//   of the first such square in raster order. The scan then restarts.
//   Throughput: one cell per cycle while in_ready is high. Each cell does
//   one read and one write of the line buffer (one RAM read port, one
//   write port); the read of the previous row's score is issued at accept,
//   and the score is finished in stage 1 and written back when stage 1
//   advances, with a bypass when the same column is read and written back
//   to back (one-column grids). out_valid is registered as stage 1 advances
//   with the last cell of a grid.
//   Stall: a pending result does not stop the scan; input is held off only
//   when another finished grid reaches the output while the previous
//   result is still not taken.
//   Reset: arst_n clears position, best square and the output channel,
//   and loads grid_width = grid_height = 1024. The line buffer is not
//   cleared; row 0 of every grid writes it before it is read.
module maximal_free_square_scan
	import mfss_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// cell input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           cell_char,
	// result output
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SCORE_W-1:0]   square_size,
	output logic [ROW_W-1:0]     corner_row,
	output logic [COL_OUT_W-1:0] corner_col,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW = 18;
	localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

	// configuration registers
	logic [GW_W-1:0]  grid_width_q;
	logic [ROW_W-1:0] grid_height_q;
	reg_idx_t         cfg_idx;
	logic             cfg_wr;

	// stage 0 position
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [XW-1:0]    w_eff;
	logic [XW-1:0]    w_last;
	logic [ROW_W-1:0] h_last;
	logic             row_end;
	logic             grid_end;
	logic             accept;

	// stage 1
	logic               valid_s1;
	logic [CW-1:0]      col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               free_s1;
	logic               row_end_s1;
	logic               grid_end_s1;
	logic               fwd_s1;
	logic [SCORE_W-1:0] fwd_score_s1;
	logic               stall;
	logic               advance_s1;

	logic [SCORE_W-1:0] rd_score;
	logic [SCORE_W-1:0] up;
	logic [SCORE_W-1:0] left;
	logic [SCORE_W-1:0] diag;
	logic [SCORE_W-1:0] min_ul;
	logic [SCORE_W-1:0] min3;
	logic [SCORE_W-1:0] score;
	logic               best_hit;
	logic [SCORE_W-1:0] best_size_nx;
	logic [ROW_W-1:0]   best_row_nx;
	logic [CW-1:0]      best_col_nx;
	logic [31:0]        best_col_wide;

	// running state
	logic [SCORE_W-1:0] left_q;
	logic [SCORE_W-1:0] diag_q;
	logic [SCORE_W-1:0] best_size_q;
	logic [ROW_W-1:0]   best_row_q;
	logic [CW-1:0]      best_col_q;

	// output register
	logic               out_valid_q;
	logic [SCORE_W-1:0] square_size_q;
	logic [ROW_W-1:0]   corner_row_q;
	logic [COL_OUT_W-1:0] corner_col_q;

	// APB decode
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (cfg_idx)
			REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_q);
			REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_q);
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[GW_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the grid size and find the last column and row
	always_comb begin
		if (grid_width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(grid_width_q) > MAX_W_X) begin
			w_eff = MAX_W_X;
		end else begin
			w_eff = XW'(grid_width_q);
		end
		w_last = w_eff - XW'(1);
		h_last = (grid_height_q == '0) ? '0 : grid_height_q - ROW_W'(1);
	end

	assign row_end  = XW'(col_q) >= w_last;
	assign grid_end = row_end && (row_q >= h_last);

	// handshake: hold input only when a second result meets a full output
	assign stall      = valid_s1 && grid_end_s1 && out_valid_q && !out_ready;
	assign in_ready   = !stall;
	assign accept     = in_valid && in_ready;
	assign advance_s1 = valid_s1 && !stall;

	// advance position at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= grid_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (advance_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload; bypass the score written in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= col_q;
			row_s1       <= row_q;
			free_s1      <= (cell_char == FREE_CHAR);
			row_end_s1   <= row_end;
			grid_end_s1  <= grid_end;
			fwd_s1       <= valid_s1 && (col_s1 == col_q);
			fwd_score_s1 <= score;
		end
	end

	// line buffer of the previous row's scores
	mfss_ram #(
		.DATA_W (SCORE_W),
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (advance_s1),
		.wr_addr (col_s1),
		.wr_data (score),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_score)
	);

	// neighbor scores, three-way minimum and saturating increment
	always_comb begin
		up   = (row_s1 == '0) ? '0 : (fwd_s1 ? fwd_score_s1 : rd_score);
		left = (col_s1 == '0) ? '0 : left_q;
		diag = (row_s1 == '0 || col_s1 == '0) ? '0 : diag_q;
		min_ul = (left < up) ? left : up;
		min3   = (diag < min_ul) ? diag : min_ul;
		if (!free_s1) begin
			score = '0;
		end else if (min3 == SCORE_MAX) begin
			score = SCORE_MAX;
		end else begin
			score = min3 + SCORE_W'(1);
		end
	end

	// keep the first strictly larger square
	always_comb begin
		best_hit     = score > best_size_q;
		best_size_nx = best_hit ? score  : best_size_q;
		best_row_nx  = best_hit ? row_s1 : best_row_q;
		best_col_nx  = best_hit ? col_s1 : best_col_q;
		best_col_wide = 32'(best_col_nx);
	end

	// update running state and load the result at the end of a grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance_s1) begin
				if (row_end_s1) begin
					left_q <= '0;
					diag_q <= '0;
				end else begin
					left_q <= score;
					diag_q <= up;
				end
				if (grid_end_s1) begin
					best_size_q <= '0;
					best_row_q  <= '0;
					best_col_q  <= '0;
					out_valid_q <= 1'b1;
				end else begin
					best_size_q <= best_size_nx;
					best_row_q  <= best_row_nx;
					best_col_q  <= best_col_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && grid_end_s1) begin
			square_size_q <= best_size_nx;
			corner_row_q  <= best_row_nx;
			corner_col_q  <= best_col_wide[COL_OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign square_size = square_size_q;
	assign corner_row  = corner_row_q;
	assign corner_col  = corner_col_q;

	// input is only held off behind a pending result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// a new result comes only from the last cell of a grid
	a_result_from_grid_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1 && grid_end_s1))
		else $error("result raised without a finished grid");

	// a zero-size result reports corner zero
	a_zero_square_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && square_size == '0 |-> corner_row == '0 && corner_col == '0)
		else $error("nonzero corner for a zero-size square");

endmodule

// ===== rtl/mfss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used as the line buffer of the square scan. No dependencies.
module mfss_ram #(
	parameter int DATA_W = 11,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
